[sv/nmf_pkg.sv]
// ----------------------------------------------------------------------------
// nmf_pkg
// Shared types and constants of the 3x3 neighbor mean filter.
// ----------------------------------------------------------------------------
package nmf_pkg;

    localparam int ROW_W    = 11;
    localparam int MAX_ROWS = 1024;
    localparam int CFG_W    = 11;
    localparam int TAP_W    = 4;
    localparam int CNT_W    = 4;

    localparam logic [TAP_W-1:0] TAP_CENTER = 4'd4;
    localparam logic [TAP_W-1:0] TAP_END    = 4'd9;

    typedef enum logic {
        CFG_ROWS    = 1'b0,
        CFG_COLUMNS = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OFS_NEG  = 2'd0,
        OFS_ZERO = 2'd1,
        OFS_POS  = 2'd2
    } ofs_t;

    typedef struct packed {
        logic capture;
        logic write_px;
        logic tap_init;
        logic tap_step;
        logic div_start;
        logic load_out;
    } nmf_cmd_t;

    typedef struct packed {
        logic pixel_ok;
        logic is_drain;
        logic out_ready;
        logic taps_done;
        logic div_busy;
        logic out_free;
    } nmf_status_t;

    // row offset of a window tap, taps in raster order
    function automatic ofs_t tap_row(logic [TAP_W-1:0] t);
        ofs_t r;
        unique case (t)
            4'd0, 4'd1, 4'd2: r = OFS_NEG;
            4'd3, 4'd4, 4'd5: r = OFS_ZERO;
            default:          r = OFS_POS;
        endcase
        return r;
    endfunction

    function automatic ofs_t tap_col(logic [TAP_W-1:0] t);
        ofs_t c;
        unique case (t)
            4'd0, 4'd3, 4'd6: c = OFS_NEG;
            4'd1, 4'd4, 4'd7: c = OFS_ZERO;
            default:          c = OFS_POS;
        endcase
        return c;
    endfunction

endpackage

[sv/neighbor_mean_filter_3x3.sv]
// ----------------------------------------------------------------------------
// neighbor_mean_filter_3x3
// Streaming mean of the eight in-frame neighbors of each pixel of a frame.
// ----------------------------------------------------------------------------
// The block handles one word at a time. A word that yields no result (a
// pixel whose window is not yet complete, a drain with nothing pending)
// passes through the write and check states back to idle; a pixel past the
// frame end, through the write state only. A word that yields a result then
// runs the read, start, divide and load states: the eight neighbors are
// fetched one per cycle from a circular line store of 2*(MAX_COLUMNS+2)
// samples, and the mean comes from a divider that produces one quotient bit
// per cycle. If the previous result is still held in the output register,
// the block waits in its last step until that word is taken. A new word is
// taken while the previous result still waits in the output register. Writing
// a register restarts the frame; after the last pixel, send drain words to
// collect the outputs still pending, the final one marked with last. The line
// store needs no clearing after reset.
module neighbor_mean_filter_3x3
    import nmf_pkg::*;
#(
    parameter int MAX_COLUMNS  = 1024,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    req_type,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SAMPLE_WIDTH-1:0] average,
    output logic                    valid_res,
    output logic                    last
);

    nmf_cmd_t    cmd;
    nmf_status_t status;

    nmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_valid (cfg_valid),
        .status    (status),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    nmf_datapath #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_type  (req_type),
        .sample    (sample),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .average   (average),
        .valid_res (valid_res),
        .last      (last)
    );

endmodule

[sv/nmf_div.sv]
// ----------------------------------------------------------------------------
// nmf_div
// Restoring divider, one quotient bit per cycle, small unsigned divisor.
// ----------------------------------------------------------------------------
module nmf_div
    import nmf_pkg::*;
#(
    parameter int NW = 19
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NW-1:0]    dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             busy,
    output logic [NW-1:0]    quotient
);

    localparam int SW_CNT = $clog2(NW + 1);

    logic [SW_CNT-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    shifted;
    logic              ge;

    assign shifted  = {rem_reg, quo_reg[NW-1]};
    assign ge       = shifted >= {1'b0, div_reg};
    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        if (start)
        begin
            cnt_next = SW_CNT'(NW);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[NW-2:0], ge};
            rem_next = ge ? CNT_W'(shifted - {1'b0, div_reg}) : shifted[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

[sv/nmf_ctrl.sv]
// ----------------------------------------------------------------------------
// nmf_ctrl
// Sequencer: accept, store, readiness check, tap reads, divide, deliver.
// ----------------------------------------------------------------------------
module nmf_ctrl
    import nmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        cfg_valid,
    input  nmf_status_t status,
    output logic        in_stall,
    output logic        cfg_ready,
    output nmf_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WRITE = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_READ  = 7'b0001000,
        S_START = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_LOAD  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   idle;

    assign idle      = state_reg == S_IDLE;
    assign cfg_ready = idle;
    assign in_stall  = !idle || cfg_valid;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !cfg_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_px = 1'b1;
                // a sample past the frame end gives nothing
                state_next   = (status.is_drain || status.pixel_ok) ? S_CHECK : S_IDLE;
            end
            S_CHECK:
            begin
                if (status.out_ready)
                begin
                    cmd.tap_init = 1'b1;
                    state_next   = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.tap_step = 1'b1;
                if (status.taps_done)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/nmf_datapath.sv]
// ----------------------------------------------------------------------------
// nmf_datapath
// Frame counters, circular line store, tap accumulation, divide, output word.
// ----------------------------------------------------------------------------
module nmf_datapath
    import nmf_pkg::*;
#(
    parameter int MAX_COLUMNS  = 1024,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  nmf_cmd_t                cmd,
    output nmf_status_t             status,
    input  logic                    cfg_write,
    input  logic                    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    req_type,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic [SAMPLE_WIDTH-1:0] average,
    output logic                    valid_res,
    output logic                    last
);

    localparam int STORE = 2 * (MAX_COLUMNS + 2);
    localparam int PW    = $clog2(STORE);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int LW    = ROW_W + CW;
    localparam int SUMW  = SAMPLE_WIDTH + 3;

    // configuration, held as effective values
    logic [ROW_W-1:0] rows_reg;
    logic [CW-1:0]    cols_reg;
    logic [31:0]      cfg_wide;

    // frame position
    logic [ROW_W-1:0] in_row_reg, out_row_reg;
    logic [CW-1:0]    in_col_reg, out_col_reg;
    logic [LW-1:0]    in_lin_reg, out_lin_reg;
    logic [PW-1:0]    in_ptr_reg, out_ptr_reg;

    logic                    type_reg;
    logic [SAMPLE_WIDTH-1:0] sample_reg;

    logic [SAMPLE_WIDTH-1:0] store_mem [STORE];
    logic [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic [PW-1:0]           rd_addr;

    logic [TAP_W-1:0] tap_reg;
    logic             acc_en_reg;
    logic [SUMW-1:0]  sum_reg;
    logic [CNT_W-1:0] count_reg;
    logic             neg_reg;

    logic [SAMPLE_WIDTH-1:0] average_reg;
    logic                    valid_res_reg, last_reg, out_valid_reg;

    logic             pixel_ok, row_ok, col_ok, tap_ok, is_last;
    logic [LW:0]      need;
    ofs_t             dr, dc;
    logic [PW:0]      row_off, col_off;
    logic [PW+1:0]    off_raw, addr_raw;
    logic [PW:0]      off;
    logic [SUMW-1:0]  magnitude, quotient, signed_q;
    logic             div_busy;

    assign cfg_wide = 32'(cfg_data);
    assign pixel_ok = !type_reg && (in_row_reg != rows_reg);
    assign row_ok   = out_row_reg != (rows_reg - 1'b1);
    assign col_ok   = out_col_reg != (cols_reg - 1'b1);
    assign is_last  = !row_ok && !col_ok;

    // position of the pixel that completes the next output's window
    assign need = {1'b0, out_lin_reg} + (row_ok ? (LW+1)'(cols_reg) : '0)
                  + (LW+1)'(col_ok);

    assign dr = tap_row(tap_reg);
    assign dc = tap_col(tap_reg);

    always_comb
    begin
        unique case (dr)
            OFS_NEG:  row_off = (PW+1)'(STORE) - (PW+1)'(cols_reg);
            OFS_POS:  row_off = (PW+1)'(cols_reg);
            default:  row_off = '0;
        endcase
        unique case (dc)
            OFS_NEG:  col_off = (PW+1)'(STORE - 1);
            OFS_POS:  col_off = (PW+1)'(1);
            default:  col_off = '0;
        endcase
    end

    assign off_raw  = {1'b0, row_off} + {1'b0, col_off};
    assign off      = (off_raw >= (PW+2)'(STORE)) ? (PW+1)'(off_raw - (PW+2)'(STORE))
                                                  : off_raw[PW:0];
    assign addr_raw = (PW+2)'(out_ptr_reg) + {1'b0, off};
    assign rd_addr  = (addr_raw >= (PW+2)'(STORE)) ? PW'(addr_raw - (PW+2)'(STORE))
                                                   : addr_raw[PW-1:0];

    // drop taps outside the frame and the center
    always_comb
    begin
        tap_ok = tap_reg != TAP_END && tap_reg != TAP_CENTER;
        if (dr == OFS_NEG && out_row_reg == '0) tap_ok = 1'b0;
        if (dr == OFS_POS && !row_ok)           tap_ok = 1'b0;
        if (dc == OFS_NEG && out_col_reg == '0) tap_ok = 1'b0;
        if (dc == OFS_POS && !col_ok)           tap_ok = 1'b0;
    end

    assign magnitude = sum_reg[SUMW-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign signed_q  = neg_reg ? (~quotient + 1'b1) : quotient;

    nmf_div #(
        .NW (SUMW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (magnitude),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign status.pixel_ok  = pixel_ok;
    assign status.is_drain  = type_reg;
    assign status.out_ready = need < {1'b0, in_lin_reg};
    assign status.taps_done = tap_reg == TAP_END;
    assign status.div_busy  = div_busy;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign average   = average_reg;
    assign valid_res = valid_res_reg;
    assign last      = last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_px && pixel_ok)
        begin
            store_mem[in_ptr_reg] <= sample_reg;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg   <= req_type;
            sample_reg <= sample;
        end
        if (cmd.tap_init)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.tap_step && acc_en_reg)
        begin
            sum_reg   <= sum_reg + SUMW'($signed(rd_data_reg));
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.div_start)
        begin
            neg_reg <= sum_reg[SUMW-1];
        end
        if (cmd.load_out)
        begin
            average_reg   <= (count_reg == '0) ? '0 : signed_q[SAMPLE_WIDTH-1:0];
            valid_res_reg <= count_reg != '0;
            last_reg      <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= ROW_W'(1);
            cols_reg      <= CW'(1);
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_lin_reg    <= '0;
            in_ptr_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_lin_reg   <= '0;
            out_ptr_reg   <= '0;
            tap_reg       <= '0;
            acc_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                if (cfg_index == CFG_ROWS)
                begin
                    if (cfg_wide == 32'd0)
                        rows_reg <= ROW_W'(1);
                    else if (cfg_wide > 32'(MAX_ROWS))
                        rows_reg <= ROW_W'(MAX_ROWS);
                    else
                        rows_reg <= ROW_W'(cfg_wide);
                end
                else
                begin
                    if (cfg_wide == 32'd0)
                        cols_reg <= CW'(1);
                    else if (cfg_wide > 32'(MAX_COLUMNS))
                        cols_reg <= CW'(MAX_COLUMNS);
                    else
                        cols_reg <= CW'(cfg_wide);
                end
                // abandon any partial frame
                in_row_reg  <= '0;
                in_col_reg  <= '0;
                in_lin_reg  <= '0;
                in_ptr_reg  <= '0;
                out_row_reg <= '0;
                out_col_reg <= '0;
                out_lin_reg <= '0;
                out_ptr_reg <= '0;
            end

            if (cmd.write_px && pixel_ok)
            begin
                in_lin_reg <= in_lin_reg + 1'b1;
                in_ptr_reg <= (in_ptr_reg == PW'(STORE - 1)) ? '0 : in_ptr_reg + 1'b1;
                if (in_col_reg == cols_reg - 1'b1)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end

            if (cmd.tap_init)
            begin
                tap_reg    <= '0;
                acc_en_reg <= 1'b0;
            end
            else if (cmd.tap_step)
            begin
                acc_en_reg <= tap_ok;
                if (tap_reg != TAP_END)
                begin
                    tap_reg <= tap_reg + 1'b1;
                end
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                if (is_last)
                begin
                    in_row_reg  <= '0;
                    in_col_reg  <= '0;
                    in_lin_reg  <= '0;
                    in_ptr_reg  <= '0;
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                    out_lin_reg <= '0;
                    out_ptr_reg <= '0;
                end
                else
                begin
                    out_lin_reg <= out_lin_reg + 1'b1;
                    out_ptr_reg <= (out_ptr_reg == PW'(STORE - 1)) ? '0
                                                                   : out_ptr_reg + 1'b1;
                    if (!col_ok)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for neighbor_mean_filter_3x3. Words are fed on the
// valid/stall input channel. Each accepted result is compared with the oldest
// expected word, from a local model of the eight-neighbor mean or the table.
// A short table of directed words comes first, then random frames of many
// sizes with drains, broken frames, random input gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import nmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_COLS    = 1024;
    localparam int  SW          = 16;
    localparam int  STORE_DEPTH = 2 * (MAX_COLS + 2);
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  ITEM_GOAL   = 1700;
    localparam int  SETTLE      = 60;
    localparam int  HOLD_CYCLES = 400;
    localparam logic REQ_PIXEL  = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    typedef struct {
        logic [SW-1:0] avg;
        logic          vres;
        logic          lst;
    } mean_word_t;

    typedef enum logic {
        ROW_CFG,
        ROW_WORD
    } row_kind_t;

    typedef struct {
        row_kind_t     kind;
        cfg_idx_t      idx;
        logic [10:0]   data;
        logic          req;
        logic [SW-1:0] smp;
        bit            typed;
        logic [SW-1:0] avg;
        logic          vres;
        logic          lst;
    } table_row_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_index = 1'b0;
    logic [10:0]   cfg_data  = '0;
    logic          in_valid  = 1'b0;
    logic          req_type  = 1'b0;
    logic [SW-1:0] sample    = '0;
    logic          out_stall = 1'b0;
    logic          cfg_ready;
    logic          in_stall;
    logic          out_valid;
    logic [SW-1:0] average;
    logic          valid_res;
    logic          last;

    // model state
    logic signed [SW-1:0] line_store [STORE_DEPTH];
    logic [10:0]          rows_reg = 11'd1;
    logic [10:0]          cols_reg = 11'd1;
    int                   in_r, in_c, out_r, out_c;

    mean_word_t pending_means[$];
    int         errors      = 0;
    int         cycles      = 0;
    int         items       = 0;
    int         idle_phase  = 0;
    bit         hold_req    = 1'b0;
    int         large_count = 0;
    int         holds       = 0;

    table_row_t directed[26];

    neighbor_mean_filter_3x3 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .average   (average),
        .valid_res (valid_res),
        .last      (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic int eff_rows();
        if (rows_reg == 0) return 1;
        return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic int eff_cols();
        if (cols_reg == 0) return 1;
        return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function automatic bit frame_clear();
        return in_r == 0 && in_c == 0 && out_r == 0 && out_c == 0;
    endfunction

    function automatic void model_config(cfg_idx_t idx, logic [10:0] val);
        if (idx == CFG_ROWS) rows_reg = val;
        else cols_reg = val;
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    endfunction

    // advance the filter model by one word; returns 1 when a mean leaves
    function automatic bit mean_step(logic req, logic [SW-1:0] smp, output mean_word_t res);
        int nr, nc, sum, cnt, rr, cc, nrows, ncols;
        nrows = eff_rows();
        ncols = eff_cols();
        res   = '{default: '0};
        if (req == REQ_PIXEL)
        begin
            if (in_r >= nrows) return 0;
            line_store[(in_r * ncols + in_c) % STORE_DEPTH] = smp;
            in_c++;
            if (in_c >= ncols)
            begin
                in_c = 0;
                in_r++;
            end
        end
        nr = (out_r + 1 < nrows) ? out_r + 1 : nrows - 1;
        nc = (out_c + 1 < ncols) ? out_c + 1 : ncols - 1;
        if (!(nr * ncols + nc < in_r * ncols + in_c)) return 0;
        sum = 0;
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
            begin
                rr = out_r + dr;
                cc = out_c + dc;
                if (rr < 0 || cc < 0 || rr >= nrows || cc >= ncols) continue;
                if (dr == 0 && dc == 0) continue;
                sum += line_store[(rr * ncols + cc) % STORE_DEPTH];
                cnt++;
            end
        res.avg  = (cnt > 0) ? SW'(sum / cnt) : '0;
        res.vres = cnt > 0;
        res.lst  = (out_r == nrows - 1) && (out_c == ncols - 1);
        if (res.lst)
        begin
            in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        end
        else
        begin
            out_c++;
            if (out_c >= ncols)
            begin
                out_c = 0;
                out_r++;
            end
        end
        return 1;
    endfunction

    task automatic report(string what, logic [SW-1:0] got, logic [SW-1:0] want);
        $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // receiver: check accepted words, drive stall
    int hold_left = 0;
    always @(posedge clk)
    begin
        mean_word_t want;
        int         pct;
        if (out_valid && !out_stall)
        begin
            if (pending_means.size() == 0)
                report("unexpected word", average, '0);
            else
            begin
                want = pending_means.pop_front();
                if (average !== want.avg) report("average", average, want.avg);
                if (valid_res !== want.vres) report("valid_res", valid_res, want.vres);
                if (last !== want.lst) report("last", last, want.lst);
            end
        end
        if (hold_req && hold_left == 0)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        pct = (idle_phase == 0) ? 63 : (idle_phase == 1) ? 32 : 0;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < pct);
    end

    task automatic send_word(logic req, logic [SW-1:0] smp, bit typed = 0,
                             logic [SW-1:0] t_avg = '0, logic t_vres = 0,
                             logic t_lst = 0);
        mean_word_t res;
        int         pct;
        int         gap;
        pct = (idle_phase == 0) ? 32 : (idle_phase == 1) ? 63 : 0;
        gap = 0;
        while ($urandom_range(0, 99) < pct && gap < 8) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        sample   <= smp;
        do @(posedge clk); while (in_stall);
        items++;
        if (mean_step(req, smp, res))
        begin
            if (typed)
            begin
                res.avg  = t_avg;
                res.vres = t_vres;
                res.lst  = t_lst;
            end
            pending_means.push_back(res);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [10:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_config(idx, val);
    endtask

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default: return SW'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [10:0] rand_dim();
        if ($urandom_range(0, 19) == 0) return 11'd0;
        return 11'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 5));
    endfunction

    initial
    begin
        int          npix;
        logic [10:0] r_val, c_val;
        bit          broken;
        bit          big;

        directed[0]  = '{ROW_WORD, CFG_ROWS, 0, REQ_PIXEL, 16'h7FFF, 1, 16'h0000, 0, 1};
        directed[1]  = '{ROW_WORD, CFG_ROWS, 0, REQ_DRAIN, 16'h0000, 0, 0, 0, 0};
        directed[2]  = '{ROW_CFG, CFG_ROWS, 11'd0, 0, 0, 0, 0, 0, 0};
        directed[3]  = '{ROW_CFG, CFG_COLUMNS, 11'd2, 0, 0, 0, 0, 0, 0};
        directed[4]  = '{ROW_WORD, CFG_ROWS, 0, REQ_PIXEL, 16'h8000, 0, 0, 0, 0};
        directed[5]  = '{ROW_WORD, CFG_ROWS, 0, REQ_PIXEL, 16'h7FFF, 1, 16'h7FFF, 1, 0};
        directed[6]  = '{ROW_WORD, CFG_ROWS, 0, REQ_DRAIN, 16'hFFFF, 1, 16'h8000, 1, 1};
        directed[7]  = '{ROW_CFG, CFG_ROWS, 11'd2, 0, 0, 0, 0, 0, 0};
        directed[8]  = '{ROW_CFG, CFG_COLUMNS, 11'd2, 0, 0, 0, 0, 0, 0};
        for (int i = 9; i < 13; i++)
            directed[i] = '{ROW_WORD, CFG_ROWS, 0, REQ_PIXEL, 16'h8000, 0, 0, 0, 0};
        for (int i = 13; i < 16; i++)
            directed[i] = '{ROW_WORD, CFG_ROWS, 0, REQ_DRAIN, 16'h0000, 0, 0, 0, 0};
        directed[16] = '{ROW_CFG, CFG_ROWS, 11'd1, 0, 0, 0, 0, 0, 0};
        directed[17] = '{ROW_CFG, CFG_COLUMNS, 11'd3, 0, 0, 0, 0, 0, 0};
        directed[18] = '{ROW_WORD, CFG_ROWS, 0, REQ_PIXEL, 16'h0100, 0, 0, 0, 0};
        directed[19] = '{ROW_WORD, CFG_ROWS, 0, REQ_PIXEL, 16'hFFFF, 0, 0, 0, 0};
        directed[20] = '{ROW_WORD, CFG_ROWS, 0, REQ_PIXEL, 16'h7FFF, 0, 0, 0, 0};
        // pixel past the frame end: dropped until drained
        directed[21] = '{ROW_WORD, CFG_ROWS, 0, REQ_PIXEL, 16'h1234, 0, 0, 0, 0};
        for (int i = 22; i < 26; i++)
            directed[i] = '{ROW_WORD, CFG_ROWS, 0, REQ_DRAIN, 16'h0000, 0, 0, 0, 0};

        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                write_reg(directed[i].idx, directed[i].data);
            else
                send_word(directed[i].req, directed[i].smp, directed[i].typed,
                          directed[i].avg, directed[i].vres, directed[i].lst);
        end

        while (items < ITEM_GOAL)
        begin
            idle_phase = (items < ITEM_GOAL / 3) ? 0 : (items < 2 * ITEM_GOAL / 3) ? 1 : 2;
            r_val = rand_dim();
            c_val = rand_dim();
            big   = 1'b0;
            if (large_count == 0 && items > 300)
            begin
                // long line or tall column, register at its extremes
                large_count++;
                big = 1'b1;
                if ($urandom_range(0, 1))
                begin
                    r_val = 11'd1;
                    c_val = 11'd2047;
                end
                else
                begin
                    r_val = 11'd1024;
                    c_val = 11'd1;
                end
            end
            if ($urandom_range(0, 1)) write_reg(CFG_ROWS, r_val);
            write_reg(CFG_COLUMNS, c_val);
            if (cols_reg != c_val || rows_reg != r_val) write_reg(CFG_ROWS, r_val);
            npix   = eff_rows() * eff_cols();
            broken = !big && ($urandom_range(0, 99) < 15);
            if (broken) npix = $urandom_range(0, npix);
            if ((holds == 0 && items > 300) || (holds == 1 && items > 1200))
            begin
                hold_req = 1'b1;
                holds++;
            end
            for (int p = 0; p < npix; p++)
            begin
                if ($urandom_range(0, 9) == 0) send_word(REQ_DRAIN, rand_sample());
                send_word(REQ_PIXEL, rand_sample());
            end
            if (!broken)
            begin
                if ($urandom_range(0, 3) == 0) send_word(REQ_PIXEL, rand_sample());
                while (!frame_clear()) send_word(REQ_DRAIN, rand_sample());
            end
        end

        in_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
